[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Operation and status codes, field widths and the cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int VALUE_BITS = 32;
	localparam int PRIO_IN_BITS = 16;
	localparam int COUNT_BITS = 5;

	// operation codes
	localparam logic [1:0] OP_ENQUEUE = 2'd0;
	localparam logic [1:0] OP_DEQUEUE = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// broadcast control from the top level to every cell
	typedef struct packed {
		logic enq;	// insert the new entry, cells at and behind it shift up
		logic deq;	// drop the head, all cells shift down
	} cell_ctl_t;

endpackage

[rtl/core/spq_if.sv]
// ----------------------------------------------------------------------------
// spq_if: request and response channels of the sorted priority queue
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic signed [31:0] item_value;
	logic [15:0]        item_priority;

	modport source (output valid, operation, item_value, item_priority, input ready);
	modport sink (input valid, operation, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic [4:0]         count_after;
	logic signed [31:0] head_value;

	modport source (output valid, popped_value, status, count_after, head_value, input ready);
	modport sink (input valid, popped_value, status, count_after, head_value, output ready);
endinterface

[rtl/core/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: priority queue kept as a sorted row of cells
// Enqueue, dequeue and clear requests with one response per request.
// ----------------------------------------------------------------------------
// The queue holds up to DEPTH (value, priority) entries in a row of cells kept
// in ascending priority order, head in cell 0. On a request, every cell
// compares its own priority with the incoming one in parallel and the row
// shifts by one place on the next clock edge, so a new request is accepted in
// every cycle and its response shows up in the output register the cycle after
// acceptance. The only thing that holds requests back is a response still
// waiting in the output register while the sink keeps ready low. A new entry
// whose priority equals the head's goes right behind the head; otherwise it
// goes in front of stored entries of equal priority. Enqueue on a full queue is
// dropped with status full, dequeue on an empty queue returns status empty, and
// operation code 3 leaves the queue as it is with status ok. Entry storage is
// not cleared at reset; only the fill count and the response valid flag are.
// ----------------------------------------------------------------------------
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH     = 16,
	parameter int PRIO_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW_EXT = (PRIO_BITS > PRIO_IN_BITS) ? PRIO_BITS : PRIO_IN_BITS;

	// fill count and response register
	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	logic [VALUE_BITS-1:0] popped_q;
	logic [1:0]            status_q;
	logic [COUNT_BITS-1:0] count_after_q;
	logic [VALUE_BITS-1:0] head_q;

	// row wiring
	logic [VALUE_BITS-1:0] cell_value [DEPTH];
	logic [PRIO_BITS-1:0]  cell_prio  [DEPTH];
	logic                  cell_stay  [DEPTH];

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  enq_ok;
	logic                  deq_ok;
	logic                  is_clear;
	logic [PW_EXT-1:0]     prio_ext;
	logic [PRIO_BITS-1:0]  prio_in;
	cell_ctl_t             ctl;
	logic [CW-1:0]         count_next;
	logic [1:0]            status_next;
	logic [VALUE_BITS-1:0] popped_next;
	logic [VALUE_BITS-1:0] head_next;

	// a request is taken whenever the output register is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// only the low PRIO_BITS of the priority are kept
	assign prio_ext = PW_EXT'(req.item_priority);
	assign prio_in  = prio_ext[PRIO_BITS-1:0];

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign enq_ok   = (req.operation == OP_ENQUEUE) && !full;
	assign deq_ok   = (req.operation == OP_DEQUEUE) && !empty;
	assign is_clear = (req.operation == OP_CLEAR);

	// cells only move on an accepted request
	assign ctl.enq = accept && enq_ok;
	assign ctl.deq = accept && deq_ok;

	// row of cells, each looks at its two neighbors and the incoming entry
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                  occ;
		logic                  stay_l;
		logic [VALUE_BITS-1:0] val_l;
		logic [PRIO_BITS-1:0]  prio_l;
		logic [VALUE_BITS-1:0] val_r;
		logic [PRIO_BITS-1:0]  prio_r;

		assign occ = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			// nothing in front of the head: it takes the new entry when it moves on an enqueue
			assign stay_l = 1'b1;
			assign val_l  = req.item_value;
			assign prio_l = prio_in;
		end else begin : g_body
			assign stay_l = cell_stay[i-1];
			assign val_l  = cell_value[i-1];
			assign prio_l = cell_prio[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			// tail holds its contents on a dequeue, it is past the count anyway
			assign val_r  = cell_value[i];
			assign prio_r = cell_prio[i];
		end else begin : g_inner
			assign val_r  = cell_value[i+1];
			assign prio_r = cell_prio[i+1];
		end

		spq_cell #(
			.PRIO_BITS (PRIO_BITS),
			.FIRST     (i == 0)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occupied    (occ),
			.new_value   (req.item_value),
			.new_prio    (prio_in),
			.stay_left   (stay_l),
			.left_value  (val_l),
			.left_prio   (prio_l),
			.right_value (val_r),
			.right_prio  (prio_r),
			.stay        (cell_stay[i]),
			.value       (cell_value[i]),
			.prio        (cell_prio[i])
		);
	end

	// response contents, computed from the row before it shifts
	always_comb begin
		count_next  = count_q;
		status_next = ST_OK;
		popped_next = '0;
		if (req.operation == OP_ENQUEUE && full) begin
			status_next = ST_FULL;
		end
		if (req.operation == OP_DEQUEUE && empty) begin
			status_next = ST_EMPTY;
		end
		if (enq_ok) begin
			count_next = count_q + CW'(1);
		end else if (deq_ok) begin
			count_next  = count_q - CW'(1);
			popped_next = cell_value[0];
		end else if (is_clear) begin
			count_next = '0;
		end

		// head after the step
		if (count_next == '0) begin
			head_next = '0;
		end else if (enq_ok && !cell_stay[0]) begin
			head_next = req.item_value;
		end else if (deq_ok) begin
			head_next = cell_value[1];
		end else begin
			head_next = cell_value[0];
		end
	end

	// fill count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			popped_q      <= popped_next;
			status_q      <= status_next;
			count_after_q <= COUNT_BITS'(count_next);
			head_q        <= head_next;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = popped_q;
	assign rsp.status       = status_q;
	assign rsp.count_after  = count_after_q;
	assign rsp.head_value   = head_q;

endmodule

[rtl/core/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry row
// Holds one value and priority, compares against the incoming priority and
// takes the new entry or a neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int  PRIO_BITS = 16,
	parameter bit  FIRST     = 1'b0
) (
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic                  occupied,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic [PRIO_BITS-1:0]  new_prio,
	input  logic                  stay_left,
	input  logic [VALUE_BITS-1:0] left_value,
	input  logic [PRIO_BITS-1:0]  left_prio,
	input  logic [VALUE_BITS-1:0] right_value,
	input  logic [PRIO_BITS-1:0]  right_prio,
	output logic                  stay,
	output logic [VALUE_BITS-1:0] value,
	output logic [PRIO_BITS-1:0]  prio
);

	logic [VALUE_BITS-1:0] value_q;
	logic [PRIO_BITS-1:0]  prio_q;

	// head keeps its place on a tie, the others let the new entry in front
	always_comb begin
		if (FIRST) begin
			stay = occupied && (prio_q <= new_prio);
		end else begin
			stay = occupied && (prio_q < new_prio);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.enq && !stay) begin
			if (stay_left) begin
				value_q <= new_value;
				prio_q  <= new_prio;
			end else begin
				value_q <= left_value;
				prio_q  <= left_prio;
			end
		end else if (ctl.deq) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

	assign value = value_q;
	assign prio  = prio_q;

endmodule

[rtl/core/spq_chk.sv]
// ----------------------------------------------------------------------------
// spq_chk: port-level checks for the sorted priority queue
// Watches the response channel and checks status against count and head.
// ----------------------------------------------------------------------------
module spq_chk
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic [VALUE_BITS-1:0] popped_value,
	input logic [1:0]            status,
	input logic [COUNT_BITS-1:0] count_after,
	input logic [VALUE_BITS-1:0] head_value
);

	// a dropped enqueue only happens on a full queue
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> count_after == COUNT_BITS'(DEPTH) &&
			popped_value == '0)
		else $error("full status with count below depth");

	// a dequeue on an empty queue leaves it empty and returns zero
	a_empty_resp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> count_after == '0 && popped_value == '0 &&
			head_value == '0)
		else $error("empty status with stored entries or nonzero data");

	// empty queue reports a zero head
	a_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && count_after == '0 |-> head_value == '0)
		else $error("nonzero head on empty queue");

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
			$stable(count_after) && $stable(head_value) && $stable(popped_value))
		else $error("response changed while stalled");

endmodule

bind sorted_priority_queue spq_chk #(
	.DEPTH (DEPTH)
) u_spq_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.popped_value (rsp.popped_value),
	.status       (rsp.status),
	.count_after  (rsp.count_after),
	.head_value   (rsp.head_value)
);
